// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NORST(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/iou_pkg.sv -----
`timescale 1ns / 1ps
package iou_pkg;
   localparam int MaxTracksDefault = 64;
   localparam int CoordBitsDefault = 12;
   localparam int IdentBits = 16;
   localparam int TimeBits = 32;
   localparam int CountBits = 7;
   localparam int HitBits = 8;

   localparam logic [1:0] CsrIouThreshold = 2'd0;
   localparam logic [1:0] CsrMaxAge = 2'd1;
   localparam logic [1:0] CsrMinHits = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_COMMIT,
      ST_COUNT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;      // latch item, clear scan
      logic scan_step;  // issue read of scan index
      logic commit;     // apply result to the table
      logic count_step; // count one slot
      logic out_load;   // present result
   } cmd_type;

   typedef struct packed {
      logic scan_last;  // scan index at final slot
      logic cmp_done;   // compare pipeline drained
      logic count_last;
   } status_type;
endpackage

// ----- hw/rtl/iou_ctrl.sv -----
`timescale 1ns / 1ps
module iou_ctrl
   import iou_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.cmp_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (sts.count_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- hw/rtl/iou_datapath.sv -----
`timescale 1ns / 1ps
module iou_datapath
   import iou_pkg::*;
#(
   parameter int MAX_TRACKS = MaxTracksDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            sts,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  req_mode,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [COORD_BITS-1:0] req_box_w,
   input  logic [COORD_BITS-1:0] req_box_h,
   input  logic [TimeBits-1:0]   req_frame_time,
   output logic [IdentBits-1:0]  rsp_track_id,
   output logic                  rsp_is_new,
   output logic                  rsp_is_confirmed,
   output logic                  rsp_table_full,
   output logic [CountBits-1:0]  rsp_live_tracks,
   output logic [CountBits-1:0]  rsp_confirmed_tracks
);
   localparam int IdxBits = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int EdgeBits = COORD_BITS + 1;
   localparam int AreaBits = 2 * EdgeBits;
   localparam int BoxBits = 4 * COORD_BITS;
   localparam int ProdBits = 2 * AreaBits;
   localparam int LiveBits = $clog2(MAX_TRACKS + 1);
   localparam int EntryBits = BoxBits + IdentBits + TimeBits + HitBits;
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(MAX_TRACKS - 1);

   // config
   logic [7:0]  thr_ff;
   logic [15:0] age_ff;
   logic [7:0]  minh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 8'd77;
         age_ff <= 16'd2000;
         minh_ff <= 8'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrIouThreshold: thr_ff <= csr_data[7:0];
            CsrMaxAge:       age_ff <= csr_data;
            CsrMinHits:      minh_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // per-slot flags in flip-flops; payload in one memory
   logic [MAX_TRACKS-1:0] valid_ff, conf_ff;
   logic [EntryBits-1:0]  mem [MAX_TRACKS];
   logic [EntryBits-1:0]  rd_ff;
   logic [IdentBits-1:0]  next_id_ff;

   // latched item
   logic                  mode_ff;
   logic [BoxBits-1:0]    box_ff;
   logic [TimeBits-1:0]   now_ff;

   // scan pipeline: stage0 read, stage1 index, stage2 geometry, stage3 products, stage4 decide
   logic [IdxBits-1:0] scan_idx_ff, cnt_idx_ff;
   logic               s1_v_ff, s2_v_ff, s3_v_ff;
   logic [IdxBits-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic               s1_live_ff, s2_live_ff, s3_live_ff;

   logic [EdgeBits-1:0] iw_ff, ih_ff, ew_ff, eh_ff;
   logic                ipos_ff;
   logic [IdentBits-1:0] s2_ident_ff, s3_ident_ff;
   logic                 s2_stale_ff;
   logic [AreaBits-1:0]  it_ff, en_ff;
   logic                 s3_pass_ff;

   // best candidate
   logic                 best_v_ff;
   logic [IdxBits-1:0]   best_idx_ff;
   logic [AreaBits-1:0]  bi_ff, bu_ff;
   logic [IdentBits-1:0] best_id_ff;
   logic [HitBits-1:0]   best_hits_ff;
   logic                 free_v_ff;
   logic [IdxBits-1:0]   free_idx_ff;
   logic [MAX_TRACKS-1:0] stale_ff;
   logic [HitBits-1:0]   s2_hits_ff, s3_hits_ff;

   // products for tie-break compare, one stage after s3
   logic                 s4_v_ff, s4_pass_ff;
   logic [IdxBits-1:0]   s4_idx_ff;
   logic [IdentBits-1:0] s4_ident_ff;
   logic [HitBits-1:0]   s4_hits_ff;
   logic [AreaBits-1:0]  s4_it_ff, s4_en_ff;
   logic [ProdBits-1:0]  p1_ff, p2_ff;
   logic                 s4_first_ff;

   // result
   logic [IdentBits-1:0]  id_ff;
   logic                  new_ff, cf_ff, full_ff;
   logic [LiveBits-1:0]   live_ff, nconf_ff;

   logic [BoxBits-1:0]   t_box;
   logic [IdentBits-1:0] t_ident;
   logic [TimeBits-1:0]  t_time;
   logic [HitBits-1:0]   t_hits;
   assign {t_box, t_ident, t_time, t_hits} = rd_ff;

   logic [EdgeBits-1:0] ax, ay, ax2, ay2, bx, by, bx2, by2;
   logic [EdgeBits-1:0] ix1, ix2, iy1, iy2, ux1, ux2, uy1, uy2;
   always_comb begin
      ax  = EdgeBits'(box_ff[0 +: COORD_BITS]);
      ay  = EdgeBits'(box_ff[COORD_BITS +: COORD_BITS]);
      ax2 = ax + EdgeBits'(box_ff[2*COORD_BITS +: COORD_BITS]);
      ay2 = ay + EdgeBits'(box_ff[3*COORD_BITS +: COORD_BITS]);
      bx  = EdgeBits'(t_box[0 +: COORD_BITS]);
      by  = EdgeBits'(t_box[COORD_BITS +: COORD_BITS]);
      bx2 = bx + EdgeBits'(t_box[2*COORD_BITS +: COORD_BITS]);
      by2 = by + EdgeBits'(t_box[3*COORD_BITS +: COORD_BITS]);
      ix1 = (ax > bx) ? ax : bx;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy1 = (ay > by) ? ay : by;
      iy2 = (ay2 < by2) ? ay2 : by2;
      ux1 = (ax < bx) ? ax : bx;
      ux2 = (ax2 > bx2) ? ax2 : bx2;
      uy1 = (ay < by) ? ay : by;
      uy2 = (ay2 > by2) ? ay2 : by2;
   end

   logic [AreaBits+8-1:0] lhs, rhs;
   assign lhs = {it_ff, 8'd0};
   assign rhs = (AreaBits + 8)'(thr_ff) * (AreaBits + 8)'(en_ff);

   logic [7:0] need;
   assign need = (minh_ff == 8'd0) ? 8'd1 : minh_ff;
   logic [HitBits-1:0] hits_inc;
   assign hits_inc = (best_hits_ff == 8'hFF) ? best_hits_ff : best_hits_ff + 8'd1;

   logic take;
   assign take = s4_v_ff && s4_pass_ff &&
                 (s4_first_ff || p1_ff > p2_ff ||
                  (p1_ff == p2_ff && s4_ident_ff < best_id_ff));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= req_mode;
         box_ff <= {req_box_h, req_box_w, req_box_y, req_box_x};
         now_ff <= req_frame_time;
      end
      if (cmd.scan_step) rd_ff <= mem[scan_idx_ff];
      // stage 1
      s1_idx_ff <= scan_idx_ff;
      s1_live_ff <= valid_ff[scan_idx_ff];
      // stage 2
      iw_ff <= ix2 - ix1;
      ih_ff <= iy2 - iy1;
      ew_ff <= ux2 - ux1;
      eh_ff <= uy2 - uy1;
      ipos_ff <= (ix2 > ix1) && (iy2 > iy1);
      s2_idx_ff <= s1_idx_ff;
      s2_live_ff <= s1_live_ff;
      s2_ident_ff <= t_ident;
      s2_hits_ff <= t_hits;
      s2_stale_ff <= (now_ff - t_time) > TimeBits'(age_ff);
      // stage 3
      it_ff <= ipos_ff ? AreaBits'(iw_ff) * AreaBits'(ih_ff) : '0;
      en_ff <= AreaBits'(ew_ff) * AreaBits'(eh_ff);
      s3_pass_ff <= ipos_ff;
      s3_idx_ff <= s2_idx_ff;
      s3_live_ff <= s2_live_ff;
      s3_ident_ff <= s2_ident_ff;
      s3_hits_ff <= s2_hits_ff;
      // stage 4: threshold and cross products
      s4_pass_ff <= s3_live_ff && s3_pass_ff && (lhs > rhs);
      s4_idx_ff <= s3_idx_ff;
      s4_ident_ff <= s3_ident_ff;
      s4_hits_ff <= s3_hits_ff;
      s4_it_ff <= it_ff;
      s4_en_ff <= en_ff;
      s4_first_ff <= !(best_v_ff || take);
      p1_ff <= ProdBits'(it_ff) * ProdBits'(take ? s4_en_ff : bu_ff);
      p2_ff <= ProdBits'(take ? s4_it_ff : bi_ff) * ProdBits'(en_ff);
      if (take) begin
         bi_ff <= s4_it_ff;
         bu_ff <= s4_en_ff;
         best_idx_ff <= s4_idx_ff;
         best_id_ff <= s4_ident_ff;
         best_hits_ff <= s4_hits_ff;
      end
      if (cmd.commit && !mode_ff) begin
         if (best_v_ff)
            mem[best_idx_ff] <= {box_ff, best_id_ff, now_ff, hits_inc};
         else if (free_v_ff)
            mem[free_idx_ff] <= {box_ff, next_id_ff, now_ff, HitBits'(1)};
      end
      if (cmd.commit) begin
         if (mode_ff) begin
            id_ff <= '0;
            new_ff <= 1'b0;
            cf_ff <= 1'b0;
            full_ff <= 1'b0;
         end else if (best_v_ff) begin
            id_ff <= best_id_ff;
            new_ff <= 1'b0;
            cf_ff <= conf_ff[best_idx_ff] || (hits_inc >= need);
            full_ff <= 1'b0;
         end else if (free_v_ff) begin
            id_ff <= next_id_ff;
            new_ff <= 1'b1;
            cf_ff <= 1'b0;
            full_ff <= 1'b0;
         end else begin
            id_ff <= '0;
            new_ff <= 1'b0;
            cf_ff <= 1'b0;
            full_ff <= 1'b1;
         end
         live_ff <= '0;
         nconf_ff <= '0;
      end
      if (cmd.count_step && valid_ff[cnt_idx_ff]) begin
         live_ff <= live_ff + LiveBits'(1);
         if (conf_ff[cnt_idx_ff]) nconf_ff <= nconf_ff + LiveBits'(1);
      end
      if (cmd.out_load) begin
         rsp_track_id <= id_ff;
         rsp_is_new <= new_ff;
         rsp_is_confirmed <= cf_ff;
         rsp_table_full <= full_ff;
         rsp_live_tracks <= CountBits'(live_ff);
         rsp_confirmed_tracks <= CountBits'(nconf_ff);
      end
   end

   // control registers of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         conf_ff <= '0;
         next_id_ff <= '0;
         scan_idx_ff <= '0;
         cnt_idx_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         best_v_ff <= 1'b0;
         free_v_ff <= 1'b0;
         free_idx_ff <= '0;
         stale_ff <= '0;
      end else begin
         s1_v_ff <= cmd.scan_step;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         if (cmd.start) begin
            scan_idx_ff <= '0;
            best_v_ff <= 1'b0;
            free_v_ff <= 1'b0;
            stale_ff <= '0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + IdxBits'(1);
            if (!valid_ff[scan_idx_ff] && !free_v_ff) begin
               free_v_ff <= 1'b1;
               free_idx_ff <= scan_idx_ff;
            end
         end
         if (s2_v_ff && s2_live_ff && s2_stale_ff) stale_ff[s2_idx_ff] <= 1'b1;
         if (take) best_v_ff <= 1'b1;
         if (cmd.commit) begin
            cnt_idx_ff <= '0;
            if (mode_ff) begin
               valid_ff <= valid_ff & ~stale_ff;
               conf_ff <= conf_ff & ~stale_ff;
            end else if (best_v_ff) begin
               if (hits_inc >= need) conf_ff[best_idx_ff] <= 1'b1;
            end else if (free_v_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
               conf_ff[free_idx_ff] <= 1'b0;
               next_id_ff <= next_id_ff + IdentBits'(1);
            end
         end
         if (cmd.count_step) cnt_idx_ff <= cnt_idx_ff + IdxBits'(1);
      end
   end

   assign sts.scan_last = (scan_idx_ff == LastIdx);
   assign sts.cmp_done = !s1_v_ff && !s2_v_ff && !s3_v_ff && !s4_v_ff;
   assign sts.count_last = (cnt_idx_ff == LastIdx);
endmodule

// ----- hw/rtl/iou_track_table_top.sv -----
`timescale 1ns / 1ps
// Greedy overlap track table.
// Input channel req_*: one item per detection (mode 0) or end of frame (mode 1).
// Result channel rsp_*: exactly one item per input item, in order.
// Config port csr_*: index 0 threshold, 1 max age in ms, 2 min hits; write
// only while no item is in flight.
// Each item goes through, from one accept to the next: the accept cycle, one
// pass over the slot memory through a single pipelined overlap/compare unit
// (one slot per cycle) and its drain, a commit cycle, a one-slot-per-cycle
// count of valid and confirmed slots, then the result register load. rsp_valid
// rises together with the loaded result registers.
// One item is processed at a time; req_stall is low only when idle.
// The result register holds while rsp_stall is high; the block stays in its
// output state until the result can be loaded, so nothing is lost.
// Reset clears all slot valid and confirmed flags at once and the ident counter,
// and sets config registers to defaults; payload memory and rsp_* data are not cleared.
module iou_track_table_top
   import iou_pkg::*;
#(
   parameter int MAX_TRACKS = MaxTracksDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [COORD_BITS-1:0] req_box_w,
   input  logic [COORD_BITS-1:0] req_box_h,
   input  logic [TimeBits-1:0]   req_frame_time,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IdentBits-1:0]  rsp_track_id,
   output logic                  rsp_is_new,
   output logic                  rsp_is_confirmed,
   output logic                  rsp_table_full,
   output logic [CountBits-1:0]  rsp_live_tracks,
   output logic [CountBits-1:0]  rsp_confirmed_tracks
);
`include "assert_macros.svh"
   cmd_type    cmd;
   status_type sts;

   iou_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   iou_datapath #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_dp (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_index, .csr_data,
      .req_mode, .req_box_x, .req_box_y, .req_box_w, .req_box_h, .req_frame_time,
      .rsp_track_id, .rsp_is_new, .rsp_is_confirmed, .rsp_table_full,
      .rsp_live_tracks, .rsp_confirmed_tracks
   );

   `ASSERT_CLK(a_one_cmd, clock, reset, $onehot0(cmd), "more than one command")
   `ASSERT_CLK(a_new_xor_full, clock, reset, !(rsp_is_new && rsp_table_full), "new and full")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, (cmd.scan_step || cmd.commit) |-> req_stall, "accept while busy")
endmodule
